>>> hdl/hbd_pkg.sv
// Shared types, constants and codes for the heartbeat detector.
package hbd_pkg;

  localparam int SampleBits  = 10;
  localparam int HistDepth   = 10;
  localparam int IvBits      = 16;
  localparam int TimeBits    = 32;
  localparam int MsBits      = 4;
  localparam int RefrBits    = 12;
  localparam int ToBits      = 16;
  localparam int CfgDataBits = 16;
  localparam int BpmBits     = 8;

  // Running sum of the interval history and its exact divide-by-depth reciprocal.
  localparam int SumBits   = IvBits + $clog2(HistDepth);
  localparam int MeanShift = SumBits + $clog2(HistDepth) + 1;
  localparam logic [MeanShift:0] MeanRecip =
    (MeanShift + 1)'((2 ** MeanShift + HistDepth - 1) / HistDepth);

  // Exact divide-by-five for a 16-bit interval.
  localparam int Div5Shift = 19;
  localparam logic [16:0] Div5Recip = 17'((2 ** Div5Shift + 4) / 5);

  localparam int DivBits = 16;
  localparam int CntBits = $clog2(DivBits);
  localparam logic [DivBits-1:0] BpmDividend = 16'd60000;
  localparam logic [BpmBits-1:0] BpmMax = 8'd255;

  localparam logic [MsBits-1:0]     MsPerSampleRst  = 4'd2;
  localparam logic [RefrBits-1:0]   RefractoryRst   = 12'd250;
  localparam logic [ToBits-1:0]     TimeoutRst      = 16'd2500;
  localparam logic [SampleBits-1:0] DefaultLevelRst = 10'd512;
  localparam logic [IvBits-1:0]     IntervalRst     = 16'd600;

  typedef enum logic [1:0] {
    CfgMsPerSample  = 2'd0,
    CfgRefractory   = 2'd1,
    CfgTimeout      = 2'd2,
    CfgDefaultLevel = 2'd3
  } hbd_cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StEval,
    StMean,
    StDiv,
    StSat,
    StPush
  } hbd_state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic eval;
    logic mean;
    logic div_step;
    logic sat;
    logic push;
  } hbd_cmd_t;

  typedef struct packed {
    logic bpm_needed;
  } hbd_sts_t;

endpackage

>>> hdl/hbd_if.sv
// Valid/ready channel interfaces for samples and detector results.
interface hbd_in_if;
  logic                           valid;
  logic                           ready;
  logic [hbd_pkg::SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface hbd_out_if;
  logic                           valid;
  logic                           ready;
  logic [hbd_pkg::BpmBits-1:0]    bpm;
  logic                           beat_ready;
  logic                           pulse_high;
  logic [hbd_pkg::IvBits-1:0]     interval_ms;
  logic [hbd_pkg::SampleBits-1:0] threshold;

  modport source (output valid, output bpm, output beat_ready, output pulse_high,
                  output interval_ms, output threshold, input ready);
  modport sink (input valid, input bpm, input beat_ready, input pulse_high,
                input interval_ms, input threshold, output ready);
endinterface

>>> hdl/hbd_ctrl.sv
// Sequencer for one sample: evaluate, optional BPM division, result hand-off.
module hbd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  hbd_pkg::hbd_sts_t sts_i,
  output hbd_pkg::hbd_cmd_t cmd_o
);
  import hbd_pkg::*;

  hbd_state_e         state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StPrep;
      end
      StPrep: state_d = StEval;
      StEval: begin
        state_d = sts_i.bpm_needed ? StMean : StPush;
      end
      StMean: state_d = StDiv;
      StDiv: begin
        if (cnt_q == {CntBits{1'b1}}) state_d = StSat;
      end
      StSat: state_d = StPush;
      StPush: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cnt_d       = cnt_q;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StPrep: cmd_o.prep = 1'b1;
      StEval: cmd_o.eval = 1'b1;
      StMean: begin
        cmd_o.mean = 1'b1;
        cnt_d      = '0;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
      end
      StSat: cmd_o.sat = 1'b1;
      StPush: cmd_o.push = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hdl/hbd_dp.sv
// Detector datapath: levels, beat timing, interval history and BPM divider.
module hbd_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  hbd_pkg::hbd_cfg_idx_e               cfg_idx_i,
  input  logic [hbd_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  logic [hbd_pkg::SampleBits-1:0]      sample_i,
  input  hbd_pkg::hbd_cmd_t                   cmd_i,
  output hbd_pkg::hbd_sts_t                   sts_o,
  output logic [hbd_pkg::BpmBits-1:0]         bpm_o,
  output logic                                beat_ready_o,
  output logic                                pulse_high_o,
  output logic [hbd_pkg::IvBits-1:0]          interval_ms_o,
  output logic [hbd_pkg::SampleBits-1:0]      threshold_o
);
  import hbd_pkg::*;

  // Configuration
  logic [MsBits-1:0]     ms_q;
  logic [RefrBits-1:0]   refr_q;
  logic [ToBits-1:0]     timeout_q;
  logic [SampleBits-1:0] deflvl_q;

  // Detector state
  logic [TimeBits-1:0]   tc_q, lbt_q;
  logic [IvBits-1:0]     bi_q;
  logic [SampleBits-1:0] thr_q, peak_q, trough_q;
  logic                  pulse_q, first_q, second_q;
  logic [BpmBits-1:0]    bpm_q;
  logic                  beat_rdy_q;

  // Per-sample working registers
  logic [SampleBits-1:0] s_q;
  logic [TimeBits-1:0]   n_q;
  logic [IvBits-1:0]     q5_q;
  logic [IvBits-1:0]     hist_q [HistDepth];
  logic [SumBits-1:0]    sum_q;
  logic [IvBits-1:0]     mean_q;
  logic [IvBits-1:0]     rem_q;
  logic [DivBits-1:0]    dvd_q, quo_q;

  // Output register
  logic [BpmBits-1:0]    out_bpm_q;
  logic                  out_beat_q, out_pulse_q;
  logic [IvBits-1:0]     out_iv_q;
  logic [SampleBits-1:0] out_thr_q;

  logic [IvBits+18:0]          prod5;
  logic [SumBits+MeanShift:0]  prod_mean;
  logic [17:0]                 gate;
  logic                        below, above, n_gate, beat, timeout, falling;
  logic [SampleBits-1:0]       trough_upd, peak_upd, mid;
  logic [IvBits-1:0]           iv_new;
  logic [IvBits:0]             rem_sh;
  logic                        rem_ge;

  assign prod5     = (IvBits + 19)'(bi_q) * (IvBits + 19)'(Div5Recip);
  assign prod_mean = (SumBits + MeanShift + 1)'(sum_q) * (SumBits + MeanShift + 1)'(MeanRecip);

  always_comb begin
    gate       = {2'b00, q5_q} + {1'b0, q5_q, 1'b0};
    below      = s_q < thr_q;
    above      = s_q > thr_q;
    n_gate     = n_q > TimeBits'(gate);
    trough_upd = (below && n_gate && (s_q < trough_q)) ? s_q : trough_q;
    peak_upd   = (above && (s_q > peak_q)) ? s_q : peak_q;
    beat       = (n_q > TimeBits'(refr_q)) && above && !pulse_q && n_gate;
    iv_new     = (|n_q[TimeBits-1:IvBits]) ? {IvBits{1'b1}} : n_q[IvBits-1:0];
    timeout    = n_q > TimeBits'(timeout_q);
    // A beat needs the sample above threshold, so it never coincides with the falling edge.
    falling    = below && pulse_q;
    if (peak_upd >= trough_upd) begin
      mid = trough_upd + ((peak_upd - trough_upd) >> 1);
    end else begin
      mid = trough_upd - ((trough_upd - peak_upd) >> 1);
    end
  end

  assign sts_o.bpm_needed = beat && !first_q;

  assign rem_sh = {rem_q, dvd_q[DivBits-1]};
  assign rem_ge = rem_sh >= {1'b0, mean_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q       <= MsPerSampleRst;
      refr_q     <= RefractoryRst;
      timeout_q  <= TimeoutRst;
      deflvl_q   <= DefaultLevelRst;
      tc_q       <= '0;
      lbt_q      <= '0;
      bi_q       <= IntervalRst;
      thr_q      <= DefaultLevelRst;
      peak_q     <= DefaultLevelRst;
      trough_q   <= DefaultLevelRst;
      pulse_q    <= 1'b0;
      first_q    <= 1'b1;
      second_q   <= 1'b0;
      bpm_q      <= '0;
      beat_rdy_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMsPerSample:  ms_q      <= cfg_data_i[MsBits-1:0];
          CfgRefractory:   refr_q    <= cfg_data_i[RefrBits-1:0];
          CfgTimeout:      timeout_q <= cfg_data_i[ToBits-1:0];
          CfgDefaultLevel: deflvl_q  <= cfg_data_i[SampleBits-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        tc_q <= tc_q + TimeBits'(ms_q);
      end
      if (cmd_i.eval) begin
        peak_q     <= peak_upd;
        trough_q   <= trough_upd;
        beat_rdy_q <= beat && !first_q;
        if (beat) begin
          pulse_q  <= 1'b1;
          bi_q     <= iv_new;
          lbt_q    <= tc_q;
          first_q  <= 1'b0;
          second_q <= first_q;
        end
        // The discarded first beat skips the falling edge and timeout handling.
        if (!(beat && first_q)) begin
          if (falling) begin
            pulse_q  <= 1'b0;
            thr_q    <= mid;
            peak_q   <= mid;
            trough_q <= mid;
          end
          if (timeout) begin
            thr_q    <= deflvl_q;
            peak_q   <= deflvl_q;
            trough_q <= deflvl_q;
            lbt_q    <= tc_q;
            first_q  <= 1'b1;
            second_q <= 1'b0;
          end
        end
      end
      if (cmd_i.sat) begin
        bpm_q <= ((mean_q == '0) || (|quo_q[DivBits-1:BpmBits])) ? BpmMax
                                                                 : quo_q[BpmBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q <= sample_i;
    end
    if (cmd_i.prep) begin
      n_q  <= tc_q - lbt_q;
      q5_q <= prod5[Div5Shift +: IvBits];
    end
    if (cmd_i.eval && beat && !first_q) begin
      // The second beat seeds every entry, so the whole history equals the new interval.
      for (int k = 0; k < HistDepth - 1; k++) begin
        hist_q[k] <= second_q ? iv_new : hist_q[k+1];
      end
      hist_q[HistDepth-1] <= iv_new;
      if (second_q) begin
        sum_q <= SumBits'(iv_new) * SumBits'(HistDepth);
      end else begin
        sum_q <= sum_q - SumBits'(hist_q[0]) + SumBits'(iv_new);
      end
    end
    if (cmd_i.mean) begin
      mean_q <= prod_mean[MeanShift +: IvBits];
      rem_q  <= '0;
      dvd_q  <= BpmDividend;
      quo_q  <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DivBits-2:0], 1'b0};
      if (rem_ge) begin
        rem_q <= IvBits'(rem_sh - {1'b0, mean_q});
        quo_q <= {quo_q[DivBits-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[IvBits-1:0];
        quo_q <= {quo_q[DivBits-2:0], 1'b0};
      end
    end
    if (cmd_i.push) begin
      out_bpm_q   <= bpm_q;
      out_beat_q  <= beat_rdy_q;
      out_pulse_q <= pulse_q;
      out_iv_q    <= bi_q;
      out_thr_q   <= thr_q;
    end
  end

  assign bpm_o         = out_bpm_q;
  assign beat_ready_o  = out_beat_q;
  assign pulse_high_o  = out_pulse_q;
  assign interval_ms_o = out_iv_q;
  assign threshold_o   = out_thr_q;

endmodule

>>> hdl/heartbeat_detector_bpm.sv
// Pulse-sensor beat detector with BPM output.
// One sample transaction on smp_i yields exactly one result transaction on res_o.
// The result carries the held BPM, a flag for a fresh BPM value, the pulse state,
// the latest beat interval in ms and the current adaptive threshold.
// A sample is taken only while the block is idle; the result sits in an output
// register, so the next sample is accepted while an earlier result still waits.
// A sample without a counted beat passes through prepare and evaluate to the
// hand-off; a counted beat also runs a mean step, a 16-step restoring divider for
// 60000 / mean interval and a saturation step before the hand-off. When res_o is
// stalled the sequencer holds in its hand-off state until the output register
// frees up, and takes no new sample meanwhile. Configuration writes on cfg_we_i
// take effect at the clock edge; the user must keep them to idle periods only, as
// the block does not enforce this. Reset clears the time counter and restores the
// default levels, the 600 ms interval and the register defaults.
module heartbeat_detector_bpm (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  hbd_in_if.sink                          smp_i,
  hbd_out_if.source                       res_o,
  input  logic                            cfg_we_i,
  input  hbd_pkg::hbd_cfg_idx_e           cfg_idx_i,
  input  logic [hbd_pkg::CfgDataBits-1:0] cfg_data_i
);
  import hbd_pkg::*;

  hbd_cmd_t cmd;
  hbd_sts_t sts;

  hbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (smp_i.valid),
    .in_ready_o  (smp_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hbd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (smp_i.sample),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .bpm_o         (res_o.bpm),
    .beat_ready_o  (res_o.beat_ready),
    .pulse_high_o  (res_o.pulse_high),
    .interval_ms_o (res_o.interval_ms),
    .threshold_o   (res_o.threshold)
  );

endmodule

>>> test/tb.sv
// Self-checking testbench for the heartbeat detector with BPM output.
`timescale 1ns / 100ps

module tb;
  import hbd_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned TailCycles = 30;
  localparam int unsigned ReportLimit = 40;
  localparam int unsigned LevelMax = (1 << SampleBits) - 1;
  localparam logic [SampleBits-1:0] CornerSamples [11] = '{
    10'd0, 10'd1023, 10'd512, 10'h155, 10'h2AA, 10'd511, 10'd513, 10'd1023, 10'd0,
    10'h3FE, 10'h001
  };

  typedef struct packed {
    logic [BpmBits-1:0]    bpm;
    logic                  beat_ready;
    logic                  pulse_high;
    logic [IvBits-1:0]     interval_ms;
    logic [SampleBits-1:0] threshold;
  } reading_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  hbd_cfg_idx_e cfg_idx;
  logic [CfgDataBits-1:0] cfg_data;

  hbd_in_if  smp_if ();
  hbd_out_if res_if ();

  heartbeat_detector_bpm u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .smp_i      (smp_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Detector state as the testbench predicts it.
  logic [MsBits-1:0]     step_ms;
  logic [RefrBits-1:0]   refr_ms;
  logic [ToBits-1:0]     tmo_ms;
  logic [SampleBits-1:0] dflt_lvl;
  logic [TimeBits-1:0]   ms_now;
  logic [TimeBits-1:0]   last_beat_ms;
  logic [IvBits-1:0]     beat_iv;
  logic [IvBits-1:0]     iv_hist [HistDepth];
  logic [SampleBits-1:0] thr_lvl;
  logic [SampleBits-1:0] peak_lvl;
  logic [SampleBits-1:0] trough_lvl;
  logic                  pulse_on;
  logic                  first_pending;
  logic                  seed_pending;
  logic [BpmBits-1:0]    bpm_held;

  logic [SampleBits-1:0] samples_to_send [$];
  reading_t              expected_readings [$];
  reading_t              oldest_reading;
  logic                  idle_on;
  int unsigned           src_gap;
  int unsigned           snk_gap;
  int unsigned           quiet_cycles;
  int unsigned           mismatches;

  always #1 clk_i = ~clk_i;

  function automatic reading_t detector_step(input logic [SampleBits-1:0] s);
    logic [TimeBits-1:0] n;
    logic [TimeBits-1:0] gate;
    int unsigned sum;
    int unsigned mean;
    int unsigned q;
    logic fresh;
    logic discarded;
    reading_t r;
    fresh = 1'b0;
    discarded = 1'b0;
    ms_now = ms_now + TimeBits'(step_ms);
    n = ms_now - last_beat_ms;
    gate = (TimeBits'(beat_iv) / 5) * 3;

    if (s < thr_lvl && n > gate && s < trough_lvl)
      trough_lvl = s;
    if (s > thr_lvl && s > peak_lvl)
      peak_lvl = s;

    if (n > TimeBits'(refr_ms) && s > thr_lvl && !pulse_on && n > gate) begin
      pulse_on = 1'b1;
      beat_iv = (n > TimeBits'(16'hFFFF)) ? 16'hFFFF : n[IvBits-1:0];
      last_beat_ms = ms_now;
      if (seed_pending) begin
        seed_pending = 1'b0;
        for (int k = 0; k < HistDepth; k++)
          iv_hist[k] = beat_iv;
      end
      if (first_pending) begin
        // The first beat only starts the interval measurement.
        first_pending = 1'b0;
        seed_pending = 1'b1;
        discarded = 1'b1;
      end else begin
        sum = 0;
        for (int k = 0; k < HistDepth - 1; k++) begin
          iv_hist[k] = iv_hist[k + 1];
          sum += iv_hist[k];
        end
        iv_hist[HistDepth - 1] = beat_iv;
        sum += beat_iv;
        mean = sum / HistDepth;
        q = (mean == 0) ? 255 : 60000 / mean;
        bpm_held = (q > 255) ? 8'd255 : q[BpmBits-1:0];
        fresh = 1'b1;
      end
    end

    if (!discarded) begin
      if (s < thr_lvl && pulse_on) begin
        pulse_on = 1'b0;
        if (peak_lvl >= trough_lvl)
          thr_lvl = trough_lvl + (peak_lvl - trough_lvl) / 2;
        else
          thr_lvl = trough_lvl - (trough_lvl - peak_lvl) / 2;
        peak_lvl = thr_lvl;
        trough_lvl = thr_lvl;
      end
      if (n > TimeBits'(tmo_ms)) begin
        thr_lvl = dflt_lvl;
        peak_lvl = dflt_lvl;
        trough_lvl = dflt_lvl;
        last_beat_ms = ms_now;
        first_pending = 1'b1;
        seed_pending = 1'b0;
      end
    end

    r.bpm = bpm_held;
    r.beat_ready = fresh;
    r.pulse_high = pulse_on;
    r.interval_ms = beat_iv;
    r.threshold = thr_lvl;
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= ReportLimit)
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
  endtask

  // Sample driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (smp_if.valid && smp_if.ready)
        expected_readings.push_back(detector_step(smp_if.sample));
      if (!smp_if.valid || smp_if.ready) begin
        if (src_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
          src_gap = $urandom_range(1, 12);
        if (src_gap != 0 || samples_to_send.size() == 0) begin
          if (src_gap != 0)
            src_gap--;
          smp_if.valid <= 1'b0;
        end else begin
          smp_if.valid <= 1'b1;
          smp_if.sample <= samples_to_send.pop_front();
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%0t: result transaction with nothing expected", $time);
        end else begin
          oldest_reading = expected_readings.pop_front();
          if (res_if.bpm !== oldest_reading.bpm)
            flag_mismatch("bpm", oldest_reading.bpm, res_if.bpm);
          if (res_if.beat_ready !== oldest_reading.beat_ready)
            flag_mismatch("beat_ready", oldest_reading.beat_ready, res_if.beat_ready);
          if (res_if.pulse_high !== oldest_reading.pulse_high)
            flag_mismatch("pulse_high", oldest_reading.pulse_high, res_if.pulse_high);
          if (res_if.interval_ms !== oldest_reading.interval_ms)
            flag_mismatch("interval_ms", oldest_reading.interval_ms, res_if.interval_ms);
          if (res_if.threshold !== oldest_reading.threshold)
            flag_mismatch("threshold", oldest_reading.threshold, res_if.threshold);
        end
      end
      if (snk_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
        snk_gap = $urandom_range(1, 12);
      if (snk_gap != 0) begin
        snk_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic drain();
    do
      @(negedge clk_i);
    while (samples_to_send.size() != 0 || smp_if.valid || expected_readings.size() != 0);
  endtask

  // Junk above each register's width must be ignored by the block.
  function automatic logic [CfgDataBits-1:0] with_junk(input int unsigned value,
                                                      input int unsigned width);
    logic [CfgDataBits-1:0] junk;
    junk = CfgDataBits'($urandom) << width;
    return junk | CfgDataBits'(value);
  endfunction

  task automatic program_registers(input int unsigned ms, input int unsigned refr,
                                   input int unsigned tmo, input int unsigned lvl);
    drain();
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CfgMsPerSample;
    cfg_data <= with_junk(ms, MsBits);
    @(posedge clk_i);
    cfg_idx <= CfgRefractory;
    cfg_data <= with_junk(refr, RefrBits);
    @(posedge clk_i);
    cfg_idx <= CfgTimeout;
    cfg_data <= with_junk(tmo, ToBits);
    @(posedge clk_i);
    cfg_idx <= CfgDefaultLevel;
    cfg_data <= with_junk(lvl, SampleBits);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    step_ms = ms[MsBits-1:0];
    refr_ms = refr[RefrBits-1:0];
    tmo_ms = tmo[ToBits-1:0];
    dflt_lvl = lvl[SampleBits-1:0];
  endtask

  // Pulse-shaped waves with jitter and noise, plus dropouts of up to 400 samples that run into a short enough timeout.
  task automatic queue_heartbeats(input int unsigned item_count);
    int unsigned queued;
    int unsigned period;
    int unsigned high_len;
    int unsigned drop_len;
    int mid;
    int amp;
    int v;
    queued = 0;
    while (queued < item_count) begin
      mid = int'(dflt_lvl);
      if (mid < 120)
        mid = 120;
      if (mid > 900)
        mid = 900;
      mid = mid + int'($urandom_range(0, 60)) - 30;
      if ($urandom_range(0, 19) == 0) begin
        drop_len = tmo_ms / step_ms + 2;
        if (drop_len > 400)
          drop_len = 400;
        v = $urandom_range(0, LevelMax);
        repeat (drop_len)
          samples_to_send.push_back(v[SampleBits-1:0]);
        queued += drop_len;
      end else begin
        period = $urandom_range(2, 30);
        high_len = $urandom_range(1, period - 1);
        amp = $urandom_range(20, 400);
        for (int k = 0; k < period; k++) begin
          if ($urandom_range(0, 11) == 0)
            v = $urandom_range(0, LevelMax);
          else
            v = ((k < high_len) ? mid + amp : mid - amp) +
                int'($urandom_range(0, amp / 4)) - amp / 8;
          if (v < 0)
            v = 0;
          if (v > int'(LevelMax))
            v = LevelMax;
          samples_to_send.push_back(v[SampleBits-1:0]);
        end
        queued += period;
      end
    end
  endtask

  initial begin
    int unsigned r_ms;
    int unsigned r_refr;
    int unsigned r_tmo;
    int unsigned r_lvl;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    smp_if.valid = 1'b0;
    smp_if.sample = '0;
    res_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgMsPerSample;
    cfg_data = '0;
    idle_on = 1'b1;
    mismatches = 0;
    quiet_cycles = 0;
    step_ms = MsPerSampleRst;
    refr_ms = RefractoryRst;
    tmo_ms = TimeoutRst;
    dflt_lvl = DefaultLevelRst;
    ms_now = '0;
    last_beat_ms = '0;
    beat_iv = IntervalRst;
    for (int k = 0; k < HistDepth; k++)
      iv_hist[k] = '0;
    thr_lvl = DefaultLevelRst;
    peak_lvl = DefaultLevelRst;
    trough_lvl = DefaultLevelRst;
    pulse_on = 1'b0;
    first_pending = 1'b1;
    seed_pending = 1'b0;
    bpm_held = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample extremes and bit patterns with the reset configuration.
    foreach (CornerSamples[i])
      samples_to_send.push_back(CornerSamples[i]);

    // Slowest clock step with the longest refractory time and the lowest default.
    program_registers(1, 4095, 65535, 0);
    queue_heartbeats(40);

    // Full-swing alternation shrinks the interval until the BPM saturates.
    program_registers(15, 0, 65535, 1023);
    for (int k = 0; k < 100; k++)
      samples_to_send.push_back((k % 2 == 0) ? SampleBits'($urandom_range(900, LevelMax))
                                             : SampleBits'($urandom_range(0, 120)));

    // A zero timeout returns to the defaults on every sample.
    program_registers(15, 4095, 0, 1023);
    queue_heartbeats(40);

    for (int p = 0; p < 7; p++) begin
      r_ms = $urandom_range(2, 15);
      r_refr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 500);
      r_tmo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(600, 4000);
      r_lvl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, LevelMax)
                                          : $urandom_range(300, 700);
      program_registers(r_ms, r_refr, r_tmo, r_lvl);
      if (p == 6)
        idle_on = 1'b0;
      queue_heartbeats((p == 6) ? 140 : 120);
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_readings.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
